// ----- rtl/core/lpm_pkg.sv -----
// Shared types, widths and constants for the polar line meter-to-pixel pipeline.
// Used by the CORDIC cells, the divider cell and the top level.
`default_nettype none
package lpm_pkg;

  localparam int CORDIC_STEPS_DEF = 28;

  localparam int CFG_W   = 22;
  localparam int RHO_W   = 32;
  localparam int THETA_W = 32;
  localparam int RHOP_W  = 40;
  localparam int ROT_W   = 34;
  localparam int ANG_W   = 34;
  localparam int VEC_W   = 48;
  localparam int NUM_W   = 64;
  localparam int MAG_W   = 63;
  localparam int DIST_W  = 45;
  localparam int REM_W   = 46;
  localparam int QUO_W   = 41;
  localparam int LOW_W   = 24;
  localparam int FRAC_W  = 17;
  localparam int GAIN_W  = 30;
  localparam int ADDR_W  = 4;

  localparam logic signed [ANG_W-1:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q29 = 34'sd843314857;
  localparam logic [GAIN_W-1:0]       INV_GAIN    = 30'd652032874;
  localparam logic [DIST_W-1:0]       TINY_D      = 45'd1074;

  localparam logic [1:0] REG_FOCAL_X  = 2'd0;
  localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] REG_CENTER_U = 2'd2;
  localparam logic [1:0] REG_CENTER_V = 2'd3;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [REM_W-1:0]  r;
    logic [QUO_W-1:0]  nb;
    logic [QUO_W-1:0]  q;
    logic [DIST_W-1:0] d;
  } div_t;

  // atan(2^-i) in Q29
  function automatic logic signed [ANG_W-1:0] atan_q29(input int idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      0:  a = 34'sd421657428;
      1:  a = 34'sd248918915;
      2:  a = 34'sd131521918;
      3:  a = 34'sd66762579;
      4:  a = 34'sd33510843;
      5:  a = 34'sd16771758;
      6:  a = 34'sd8387925;
      7:  a = 34'sd4194219;
      8:  a = 34'sd2097141;
      9:  a = 34'sd1048575;
      10: a = 34'sd524288;
      11: a = 34'sd262144;
      12: a = 34'sd131072;
      13: a = 34'sd65536;
      14: a = 34'sd32768;
      15: a = 34'sd16384;
      16: a = 34'sd8192;
      17: a = 34'sd4096;
      18: a = 34'sd2048;
      19: a = 34'sd1024;
      20: a = 34'sd512;
      21: a = 34'sd256;
      22: a = 34'sd128;
      23: a = 34'sd64;
      24: a = 34'sd32;
      25: a = 34'sd16;
      26: a = 34'sd8;
      27: a = 34'sd4;
      28: a = 34'sd2;
      29: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lpm_rot_cell.sv -----
// One rotation-mode CORDIC step with a registered output and a carried payload.
// Depends on lpm_pkg.
`default_nettype none
module lpm_rot_cell
  import lpm_pkg::*;
#(
  parameter int IDX = 0,
  parameter int PW  = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire rot_t          in_st,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_valid,
  output rot_t               out_st,
  output logic [PW-1:0]      out_pay
);

  rot_t st_next;
  logic signed [ROT_W-1:0] dx;
  logic signed [ROT_W-1:0] dy;

  always_comb begin
    dx = in_st.y >>> IDX;
    dy = in_st.x >>> IDX;
    if (!in_st.z[ANG_W-1]) begin
      st_next.x = in_st.x - dx;
      st_next.y = in_st.y + dy;
      st_next.z = in_st.z - atan_q29(IDX);
    end else begin
      st_next.x = in_st.x + dx;
      st_next.y = in_st.y - dy;
      st_next.z = in_st.z + atan_q29(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_st  <= st_next;
    out_pay <= in_pay;
  end

endmodule
`default_nettype wire

// ----- rtl/core/lpm_vec_cell.sv -----
// One vectoring-mode CORDIC step with a registered output and a carried payload.
// Depends on lpm_pkg.
`default_nettype none
module lpm_vec_cell
  import lpm_pkg::*;
#(
  parameter int IDX = 0,
  parameter int PW  = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire vec_t          in_st,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_valid,
  output vec_t               out_st,
  output logic [PW-1:0]      out_pay
);

  vec_t st_next;
  logic signed [VEC_W-1:0] dx;
  logic signed [VEC_W-1:0] dy;

  always_comb begin
    dx = in_st.y >>> IDX;
    dy = in_st.x >>> IDX;
    if (!in_st.y[VEC_W-1]) begin
      st_next.x = in_st.x + dx;
      st_next.y = in_st.y - dy;
      st_next.z = in_st.z + atan_q29(IDX);
    end else begin
      st_next.x = in_st.x - dx;
      st_next.y = in_st.y + dy;
      st_next.z = in_st.z - atan_q29(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_st  <= st_next;
    out_pay <= in_pay;
  end

endmodule
`default_nettype wire

// ----- rtl/core/lpm_div_cell.sv -----
// One restoring-division step: shifts in a dividend bit, yields one quotient bit.
// Depends on lpm_pkg.
`default_nettype none
module lpm_div_cell
  import lpm_pkg::*;
#(
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire div_t          in_st,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_valid,
  output div_t               out_st,
  output logic [PW-1:0]      out_pay
);

  div_t st_next;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] dext;
  logic             ge;

  always_comb begin
    trial = {in_st.r[REM_W-2:0], in_st.nb[QUO_W-1]};
    dext  = {1'b0, in_st.d};
    ge    = (trial >= dext);
    st_next.r  = ge ? (trial - dext) : trial;
    st_next.nb = {in_st.nb[QUO_W-2:0], 1'b0};
    st_next.q  = {in_st.q[QUO_W-2:0], ge};
    st_next.d  = in_st.d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_st  <= st_next;
    out_pay <= in_pay;
  end

endmodule
`default_nettype wire

// ----- rtl/core/line_polar_meter_to_pixel_unit.sv -----
// Top level: polar line conversion from metric to pixel frame, APB register block.
// Depends on lpm_pkg, lpm_rot_cell, lpm_vec_cell, lpm_div_cell.
//
//   channel   ports                                   handshake
//   input     rho_meter, theta_meter                  start, busy
//   result    rho_pixel, theta_pixel, status          done (one-cycle strobe)
//   config    psel penable pwrite paddr pwdata prdata APB, pready tied high
//
// One item per cycle; busy stays low. The pipeline is two CORDIC cell rows of
// CORDIC_STEPS cells, a 41-cell restoring divider, and eight arithmetic stages
// around them.
// Synchronous reset clears the valid bits of every stage; config regs reload.
// Results leave on done and are not held; the receiver takes each on its cycle.
`default_nettype none
module line_polar_meter_to_pixel_unit
  import lpm_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [RHO_W-1:0]   rho_meter,
  input  wire logic signed [THETA_W-1:0] theta_meter,
  output logic                           done,
  output logic signed [RHOP_W-1:0]       rho_pixel,
  output logic signed [THETA_W-1:0]      theta_pixel,
  output logic                           status,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ADDR_W-1:0]         paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int LAT  = 2*CORDIC_STEPS + 49;
  localparam int RP_W = RHO_W + 1;
  localparam int DP_W = THETA_W + 3;

  // ---------------- registers ----------------
  logic [CFG_W-1:0] focal_x, focal_y, center_u, center_v;
  logic [2*CFG_W-1:0] fxfy, cufy, cvfx;
  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= 22'd256000;
      focal_y  <= 22'd256000;
      center_u <= 22'd81920;
      center_v <= 22'd61440;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FOCAL_X:  focal_x  <= pwdata[CFG_W-1:0];
        REG_FOCAL_Y:  focal_y  <= pwdata[CFG_W-1:0];
        REG_CENTER_U: center_u <= pwdata[CFG_W-1:0];
        REG_CENTER_V: center_v <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
    fxfy <= focal_x * focal_y;
    cufy <= center_u * focal_y;
    cvfx <= center_v * focal_x;
  end

  always_comb begin
    case (paddr[3:2])
      REG_FOCAL_X:  prdata = {10'd0, focal_x};
      REG_FOCAL_Y:  prdata = {10'd0, focal_y};
      REG_CENTER_U: prdata = {10'd0, center_u};
      REG_CENTER_V: prdata = {10'd0, center_v};
      default:      prdata = '0;
    endcase
  end

  // ---------------- input stage: half-turn reduction ----------------
  logic                rv   [0:CORDIC_STEPS];
  rot_t                rst_q[0:CORDIC_STEPS];
  logic [RP_W-1:0]     rpay [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] th_ext;
  logic signed [ANG_W-1:0] th_red;
  logic                th_flip;

  always_comb begin
    th_ext = {{(ANG_W-THETA_W){theta_meter[THETA_W-1]}}, theta_meter};
    if (th_ext > HALF_PI_Q29) begin
      th_red  = th_ext - PI_Q29;
      th_flip = 1'b1;
    end else if (th_ext < -HALF_PI_Q29) begin
      th_red  = th_ext + PI_Q29;
      th_flip = 1'b1;
    end else begin
      th_red  = th_ext;
      th_flip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else begin
      rv[0] <= start && !busy;
    end
    rst_q[0].x <= {{(ROT_W-GAIN_W){1'b0}}, INV_GAIN};
    rst_q[0].y <= '0;
    rst_q[0].z <= th_red;
    rpay[0]    <= {rho_meter, th_flip};
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    lpm_rot_cell #(.IDX(i), .PW(RP_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (rv[i]),
      .in_st    (rst_q[i]),
      .in_pay   (rpay[i]),
      .out_valid(rv[i+1]),
      .out_st   (rst_q[i+1]),
      .out_pay  (rpay[i+1])
    );
  end

  // ---------------- stage A: products ----------------
  logic signed [ROT_W-1:0] c_a, s_a;
  logic signed [RHO_W-1:0] rho_a;
  logic va;
  logic signed [CFG_W+ROT_W:0] px_a, py_a;
  logic signed [CFG_W+RHO_W:0] n1l_a, n1h_a;
  logic signed [CFG_W+ROT_W:0] n2l_a, n2h_a, n3l_a, n3h_a;

  always_comb begin
    rho_a = rpay[CORDIC_STEPS][RP_W-1:1];
    c_a   = rpay[CORDIC_STEPS][0] ? -rst_q[CORDIC_STEPS].x : rst_q[CORDIC_STEPS].x;
    s_a   = rpay[CORDIC_STEPS][0] ? -rst_q[CORDIC_STEPS].y : rst_q[CORDIC_STEPS].y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= rv[CORDIC_STEPS];
    end
    px_a  <= $signed({1'b0, focal_y}) * c_a;
    py_a  <= $signed({1'b0, focal_x}) * s_a;
    n1l_a <= $signed({1'b0, fxfy[CFG_W-1:0]}) * rho_a;
    n1h_a <= $signed({1'b0, fxfy[2*CFG_W-1:CFG_W]}) * rho_a;
    n2l_a <= $signed({1'b0, cufy[CFG_W-1:0]}) * c_a;
    n2h_a <= $signed({1'b0, cufy[2*CFG_W-1:CFG_W]}) * c_a;
    n3l_a <= $signed({1'b0, cvfx[CFG_W-1:0]}) * s_a;
    n3h_a <= $signed({1'b0, cvfx[2*CFG_W-1:CFG_W]}) * s_a;
  end

  // ---------------- stage B: rounding adds ----------------
  localparam int WIDE_W = 80;
  logic signed [WIDE_W-1:0] w1, w2, w3;
  logic signed [CFG_W+ROT_W:0] sx_b, sy_b;
  logic vb;
  logic signed [VEC_W-1:0] vx_b, vy_b;
  logic signed [NUM_W-1:0] t1_b, t2_b, t3_b;

  always_comb begin
    sx_b = px_a + 57'sd128;
    sy_b = py_a + 57'sd128;
    w1 = $signed({{(WIDE_W-CFG_W-RHO_W-1-CFG_W){n1h_a[CFG_W+RHO_W]}}, n1h_a, {CFG_W{1'b0}}})
       + $signed({{(WIDE_W-CFG_W-RHO_W-1){n1l_a[CFG_W+RHO_W]}}, n1l_a})
       + 80'sd8192;
    w2 = $signed({{(WIDE_W-CFG_W-ROT_W-1-CFG_W){n2h_a[CFG_W+ROT_W]}}, n2h_a, {CFG_W{1'b0}}})
       + $signed({{(WIDE_W-CFG_W-ROT_W-1){n2l_a[CFG_W+ROT_W]}}, n2l_a})
       + 80'sd32768;
    w3 = $signed({{(WIDE_W-CFG_W-ROT_W-1-CFG_W){n3h_a[CFG_W+ROT_W]}}, n3h_a, {CFG_W{1'b0}}})
       + $signed({{(WIDE_W-CFG_W-ROT_W-1){n3l_a[CFG_W+ROT_W]}}, n3l_a})
       + 80'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    vx_b <= sx_b[VEC_W+7:8];
    vy_b <= sy_b[VEC_W+7:8];
    t1_b <= w1[NUM_W+13:14];
    t2_b <= w2[NUM_W+15:16];
    t3_b <= w3[NUM_W+15:16];
  end

  // ---------------- stage C: numerator sum, vectoring setup ----------------
  logic             vv   [0:CORDIC_STEPS];
  vec_t             vst_q[0:CORDIC_STEPS];
  logic [NUM_W-1:0] vpay [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else begin
      vv[0] <= vb;
    end
    vpay[0] <= t1_b + t2_b + t3_b;
    if (vx_b[VEC_W-1]) begin
      vst_q[0].x <= -vx_b;
      vst_q[0].y <= -vy_b;
      vst_q[0].z <= vy_b[VEC_W-1] ? -PI_Q29 : PI_Q29;
    end else begin
      vst_q[0].x <= vx_b;
      vst_q[0].y <= vy_b;
      vst_q[0].z <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    lpm_vec_cell #(.IDX(i), .PW(NUM_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vv[i]),
      .in_st    (vst_q[i]),
      .in_pay   (vpay[i]),
      .out_valid(vv[i+1]),
      .out_st   (vst_q[i+1]),
      .out_pay  (vpay[i+1])
    );
  end

  // ---------------- stage D: gain products, magnitude ----------------
  localparam int HALF_X = 23;
  logic vd;
  logic [HALF_X+GAIN_W-1:0] dl_d, dh_d;
  logic [MAG_W-1:0]         mag_d;
  logic                     neg_d;
  logic [THETA_W-1:0]       th_d;
  logic [NUM_W-1:0]         num_v;
  logic [NUM_W-1:0]         abs_v;
  logic [2*HALF_X-1:0]      xf;

  always_comb begin
    num_v = vpay[CORDIC_STEPS];
    abs_v = num_v[NUM_W-1] ? (~num_v + 64'd1) : num_v;
    xf    = vst_q[CORDIC_STEPS].x[2*HALF_X-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vv[CORDIC_STEPS];
    end
    dl_d  <= xf[HALF_X-1:0] * INV_GAIN;
    dh_d  <= xf[2*HALF_X-1:HALF_X] * INV_GAIN;
    mag_d <= abs_v[MAG_W-1:0];
    neg_d <= num_v[NUM_W-1];
    th_d  <= vst_q[CORDIC_STEPS].z[THETA_W-1:0];
  end

  // ---------------- stage E: distance ----------------
  localparam int DS_W = 2*HALF_X + GAIN_W + 1;
  logic ve;
  logic [DS_W-1:0]   ds;
  logic [DIST_W-1:0] d_e;
  logic [MAG_W-1:0]  mag_e;
  logic              neg_e;
  logic [THETA_W-1:0] th_e;

  assign ds = {1'b0, dh_d, {HALF_X{1'b0}}} + {{(DS_W-HALF_X-GAIN_W){1'b0}}, dl_d}
            + {{(DS_W-GAIN_W){1'b0}}, 30'd536870912};

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= vd;
    end
    d_e   <= ds[DIST_W+29:30];
    mag_e <= mag_d;
    neg_e <= neg_d;
    th_e  <= th_d;
  end

  // ---------------- stage F: divider setup ----------------
  logic             dv   [0:QUO_W];
  div_t             dst_q[0:QUO_W];
  logic [DP_W-1:0]  dpay [0:QUO_W];
  logic [MAG_W-LOW_W-1:0] mag_hi;

  assign mag_hi = mag_e[MAG_W-1:LOW_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= ve;
    end
    dst_q[0].r  <= {{(REM_W-MAG_W+LOW_W){1'b0}}, mag_hi};
    dst_q[0].nb <= {mag_e[LOW_W-1:0], {FRAC_W{1'b0}}};
    dst_q[0].q  <= '0;
    dst_q[0].d  <= d_e;
    // neg, saturate, error, theta
    dpay[0] <= {neg_e,
                ({{(DIST_W-MAG_W+LOW_W){1'b0}}, mag_hi} >= d_e),
                (d_e < TINY_D),
                th_e};
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    lpm_div_cell #(.PW(DP_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv[i]),
      .in_st    (dst_q[i]),
      .in_pay   (dpay[i]),
      .out_valid(dv[i+1]),
      .out_st   (dst_q[i+1]),
      .out_pay  (dpay[i+1])
    );
  end

  // ---------------- output stage: round, saturate ----------------
  logic [QUO_W:0]   qinc;
  logic [QUO_W-1:0] res;
  logic [QUO_W-1:0] res_c;
  logic             o_neg, o_sat, o_err;
  logic [RHOP_W-1:0] rho_next;

  localparam logic [QUO_W-1:0] RES_SAT  = {1'b1, {(QUO_W-1){1'b0}}};
  localparam logic [QUO_W-1:0] NEG_LIM  = {2'b01, {(QUO_W-2){1'b0}}};
  localparam logic [QUO_W-1:0] POS_LIM  = {2'b00, {(QUO_W-2){1'b1}}};

  always_comb begin
    o_neg = dpay[QUO_W][DP_W-1];
    o_sat = dpay[QUO_W][DP_W-2];
    o_err = dpay[QUO_W][DP_W-3];
    qinc  = {1'b0, dst_q[QUO_W].q} + {{QUO_W{1'b0}}, 1'b1};
    res   = o_sat ? RES_SAT : qinc[QUO_W:1];
    if (o_neg) begin
      res_c    = (res > NEG_LIM) ? NEG_LIM : res;
      rho_next = ~res_c[RHOP_W-1:0] + 40'd1;
    end else begin
      res_c    = (res > POS_LIM) ? POS_LIM : res;
      rho_next = res_c[RHOP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[QUO_W];
    end
    if (o_err) begin
      rho_pixel   <= '0;
      theta_pixel <= '0;
      status      <= 1'b1;
    end else begin
      rho_pixel   <= rho_next;
      theta_pixel <= dpay[QUO_W][THETA_W-1:0];
      status      <= 1'b0;
    end
  end

  // ---------------- checks ----------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("item did not complete after the pipeline latency");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching item");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (rho_pixel == '0 && theta_pixel == '0))
    else $error("error result carries nonzero fields");

endmodule
`default_nettype wire

// ----- bench/line_polar_meter_to_pixel_unit_test.sv -----
// Self-checking bench for line_polar_meter_to_pixel_unit: directed table, then random lines
// under several intrinsics settings, each checked by a bit-exact converter or error value.
// Depends on lpm_pkg and the unit RTL.
`timescale 1ns / 1ps
module line_polar_meter_to_pixel_unit_test;
  import lpm_pkg::*;

  localparam int STEPS = 28;
  localparam longint PI_V = 1686629713;
  localparam longint HALF_PI_V = 843314857;
  localparam longint GAIN_V = 652032874;
  localparam longint MAX_CFG = 4194303;
  localparam longint ATAN_TAB [0:29] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
    8, 4, 2, 1};

  typedef struct {
    logic signed [RHOP_W-1:0]  rho;
    logic signed [THETA_W-1:0] theta;
    logic                      stat;
  } line_px_t;

  typedef struct {
    logic signed [RHO_W-1:0]   rho;
    logic signed [THETA_W-1:0] theta;
    bit                        zero_focal;
    bit                        typed;
    line_px_t                  want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [RHO_W-1:0] rho_meter = '0;
  logic signed [THETA_W-1:0] theta_meter = '0;
  logic done;
  logic signed [RHOP_W-1:0] rho_pixel;
  logic signed [THETA_W-1:0] theta_pixel;
  logic status;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  longint fx_m, fy_m, cu_m, cv_m;
  line_px_t pending_lines[$];
  int mismatches = 0;
  int idle_pct = 0;

  line_polar_meter_to_pixel_unit uut (.*);

  always #6 clk = ~clk;

  // round-half-up of p*v / 2^k
  function automatic longint mul_round(longint p, longint v, int k);
    longint hi, lo;
    hi = v >>> k;
    lo = v & ((64'sd1 << k) - 1);
    return p * hi + ((p * lo + (64'sd1 << (k - 1))) >>> k);
  endfunction

  function automatic line_px_t convert_line(logic signed [RHO_W-1:0] rho_in,
                                            logic signed [THETA_W-1:0] theta_in);
    line_px_t o;
    longint z, x, y, dx, dy, c, s, vx, vy, num;
    longint unsigned d, ah, al, lo, mag, q, r, res;
    bit flip;
    z = theta_in;
    flip = 0;
    if (z > HALF_PI_V) begin
      z -= PI_V;
      flip = 1;
    end else if (z < -HALF_PI_V) begin
      z += PI_V;
      flip = 1;
    end
    x = GAIN_V;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    vx = (fy_m * c + 128) >>> 8;
    vy = (fx_m * s + 128) >>> 8;
    z = 0;
    if (vx < 0) begin
      z = (vy >= 0) ? PI_V : -PI_V;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; z += ATAN_TAB[i];
      end else begin
        vx -= dx; vy += dy; z -= ATAN_TAB[i];
      end
    end
    ah = longint'(vx) >> 15;
    al = vx & 32767;
    lo = (al * GAIN_V + (64'd1 << 29)) >> 15;
    d = (ah * GAIN_V + lo) >> 15;
    if (d < 1074) begin
      o.rho = '0;
      o.theta = '0;
      o.stat = 1;
      return o;
    end
    num = mul_round(fx_m * fy_m, rho_in, 14) + mul_round(cu_m * fy_m, c, 16)
        + mul_round(cv_m * fx_m, s, 16);
    mag = num < 0 ? -num : num;
    q = mag / d;
    r = mag % d;
    if (q >= (64'd1 << 24)) begin
      res = 64'd1 << 40;
    end else begin
      for (int b = 0; b < 17; b++) begin
        r <<= 1;
        q <<= 1;
        if (r >= d) begin
          r -= d;
          q |= 1;
        end
      end
      res = (q + 1) >> 1;
    end
    if (num < 0) begin
      if (res > (64'd1 << 39)) res = 64'd1 << 39;
      o.rho = RHOP_W'(64'd0 - res);
    end else begin
      if (res > (64'd1 << 39) - 1) res = (64'd1 << 39) - 1;
      o.rho = RHOP_W'(res);
    end
    o.theta = THETA_W'(z);
    o.stat = 0;
    return o;
  endfunction

  task automatic write_reg(logic [1:0] idx, longint value);
    logic [31:0] w;
    w = value[31:0];
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= w;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_FOCAL_X:  fx_m = w & MAX_CFG;
      REG_FOCAL_Y:  fy_m = w & MAX_CFG;
      REG_CENTER_U: cu_m = w & MAX_CFG;
      REG_CENTER_V: cv_m = w & MAX_CFG;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_intrinsics(longint fx, longint fy, longint cu, longint cv);
    // upper bits of the data word are junk; the unit keeps 22 bits
    write_reg(REG_FOCAL_X, fx | (longint'($urandom_range(0, 1023)) << 22));
    write_reg(REG_FOCAL_Y, fy | (longint'($urandom_range(0, 1023)) << 22));
    write_reg(REG_CENTER_U, cu | (longint'($urandom_range(0, 1023)) << 22));
    write_reg(REG_CENTER_V, cv | (longint'($urandom_range(0, 1023)) << 22));
  endtask

  task automatic drain();
    start <= 0;
    while (pending_lines.size() != 0) @(posedge clk);
  endtask

  task automatic send_line(logic signed [RHO_W-1:0] r, logic signed [THETA_W-1:0] t,
                           bit typed, line_px_t want);
    start <= 1;
    rho_meter <= r;
    theta_meter <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_lines.push_back(typed ? want : convert_line(r, t));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_theta();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'(longint'($urandom_range(0, 32'd3373259426)) - PI_V);
  endfunction

  always @(posedge clk) begin
    line_px_t w;
    if (!rst && done) begin
      if (pending_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: rho %0d theta %0d status %0d",
                                       rho_pixel, theta_pixel, status);
      end else begin
        w = pending_lines.pop_front();
        if (w.rho !== rho_pixel || w.theta !== theta_pixel || w.stat !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want rho %0d theta %0d status %0d, got %0d %0d %0d",
                     w.rho, w.theta, w.stat, rho_pixel, theta_pixel, status);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    line_px_t err_px;
    bit zf;
    int n;
    longint fx, fy, cu, cv;
    err_px.rho = '0;
    err_px.theta = '0;
    err_px.stat = 1;
    fx_m = 256000; fy_m = 256000; cu_m = 81920; cv_m = 61440;
    // angles: zero, quadrant edges, both sides of them, input extremes
    foreach (ATAN_TAB[i]) if (i < 14) begin
      rw.zero_focal = 0;
      rw.typed = 0;
      rw.want = err_px;
      case (i)
        0:  begin rw.rho = 0;            rw.theta = 0; end
        1:  begin rw.rho = 32'h7FFFFFFF; rw.theta = 32'(PI_V); end
        2:  begin rw.rho = 32'h80000000; rw.theta = 32'(-PI_V); end
        3:  begin rw.rho = 1;            rw.theta = 32'(HALF_PI_V); end
        4:  begin rw.rho = -1;           rw.theta = 32'(-HALF_PI_V); end
        5:  begin rw.rho = 32'h10000000; rw.theta = 32'(HALF_PI_V + 1); end
        6:  begin rw.rho = 32'hF0000000; rw.theta = 32'(-HALF_PI_V - 1); end
        7:  begin rw.rho = 32'h7FFFFFFF; rw.theta = 32'h7FFFFFFF; end
        8:  begin rw.rho = 32'h80000000; rw.theta = 32'h80000000; end
        9:  begin rw.rho = 12345;        rw.theta = 32'(PI_V - 1); end
        10: begin rw.rho = 0;            rw.theta = 1; end
        11: begin rw.rho = 0;            rw.theta = -1; end
        12: begin rw.rho = 32'h7FFFFFFF; rw.theta = 32'(-PI_V + 1); end
        13: begin rw.rho = 32'h80000000; rw.theta = 32'hFFFFFFFF; end
        default: ;
      endcase
      rows.push_back(rw);
    end
    // both focals zero: distance vanishes, error status
    rw.zero_focal = 1;
    rw.typed = 1;
    rw.rho = 32'h7FFFFFFF; rw.theta = 0; rows.push_back(rw);
    rw.rho = 32'h80000000; rw.theta = 32'(HALF_PI_V); rows.push_back(rw);
    rw.rho = 5; rw.theta = 32'h80000000; rows.push_back(rw);

    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    zf = 0;
    foreach (rows[i]) begin
      if (rows[i].zero_focal != zf) begin
        drain();
        zf = rows[i].zero_focal;
        set_intrinsics(0, 0, MAX_CFG, MAX_CFG);
      end
      send_line(rows[i].rho, rows[i].theta, rows[i].typed, rows[i].want);
    end

    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin fx = MAX_CFG; fy = MAX_CFG; cu = MAX_CFG; cv = MAX_CFG; end
        1: begin fx = 256000; fy = 256000; cu = 0; cv = 0; end
        2: begin fx = 1; fy = 1; cu = MAX_CFG; cv = MAX_CFG; end
        3: begin fx = 0; fy = $urandom_range(1, MAX_CFG); cu = 0; cv = MAX_CFG; end
        default: begin
          fx = $urandom_range(0, MAX_CFG); fy = $urandom_range(0, MAX_CFG);
          cu = $urandom_range(0, MAX_CFG); cv = $urandom_range(0, MAX_CFG);
        end
      endcase
      set_intrinsics(fx, fy, cu, cv);
      repeat (85) begin
        idle_pct = n < 170 ? 13 : (n < 340 ? 47 : 0);
        send_line($urandom, rand_theta(), 0, err_px);
        n++;
      end
    end

    drain();
    repeat (120) @(posedge clk);
    if (mismatches == 0 && pending_lines.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lpm_pkg.sv
rtl/core/lpm_rot_cell.sv
rtl/core/lpm_vec_cell.sv
rtl/core/lpm_div_cell.sv
rtl/core/line_polar_meter_to_pixel_unit.sv
bench/line_polar_meter_to_pixel_unit_test.sv
